@@ rtl/core/cdts_pkg.sv @@
// Shared types and constants of the countdown timer / stopwatch core.
`default_nettype none

package cdts_pkg;

    localparam int MS_W  = 27;
    localparam int SEC_W = 17;
    localparam int MIN_W = 11;
    localparam int SS_W  = 6;
    localparam int OP_W  = 3;
    localparam int PH_W  = 2;

    // floor(x / 1000) for x < 2**27 as (x * RECIP_1000) >> SHIFT_1000
    localparam int           SHIFT_1000 = 37;
    localparam int           R1000_W    = 28;
    localparam logic [R1000_W-1:0] RECIP_1000 = 28'd137438954;

    // floor(x / 60) for x < 2**17 as (x * RECIP_60) >> SHIFT_60
    localparam int           SHIFT_60 = 23;
    localparam int           R60_W    = 18;
    localparam logic [R60_W-1:0] RECIP_60 = 18'd139811;

    typedef enum logic [PH_W-1:0] {
        PH_IDLE     = 2'd0,
        PH_RUNNING  = 2'd1,
        PH_PAUSED   = 2'd2,
        PH_FINISHED = 2'd3
    } t_phase;

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_START        = 3'd1,
        OP_PAUSE        = 3'd2,
        OP_RESET        = 3'd3,
        OP_ADD_TIME     = 3'd4,
        OP_SET_DURATION = 3'd5
    } t_op;

    typedef struct packed {
        logic [PH_W-1:0] run_state;
        logic [MS_W-1:0] shown_ms;
        logic            finished_pulse;
        logic            state_changed;
    } t_beat;

endpackage

`default_nettype wire

@@ rtl/core/cdts_in_if.sv @@
// Input channel of the countdown timer / stopwatch core.
`default_nettype none

interface cdts_in_if;
    logic                       valid;
    logic                       ready;
    logic [cdts_pkg::OP_W-1:0]  operation;
    logic [cdts_pkg::SEC_W-1:0] amount_seconds;

    modport source (output valid, output operation, output amount_seconds, input ready);
    modport sink   (input valid, input operation, input amount_seconds, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdts_out_if.sv @@
// Result channel of the countdown timer / stopwatch core.
`default_nettype none

interface cdts_out_if;
    logic                       valid;
    logic                       ready;
    logic [cdts_pkg::PH_W-1:0]  run_state;
    logic [cdts_pkg::MS_W-1:0]  shown_ms;
    logic [cdts_pkg::MIN_W-1:0] shown_minutes;
    logic [cdts_pkg::SS_W-1:0]  shown_seconds;
    logic                       finished_pulse;
    logic                       state_changed;

    modport source (output valid, output run_state, output shown_ms, output shown_minutes,
                    output shown_seconds, output finished_pulse, output state_changed,
                    input ready);
    modport sink   (input valid, input run_state, input shown_ms, input shown_minutes,
                    input shown_seconds, input finished_pulse, input state_changed,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdts_time_split.sv @@
// Pipeline that splits the shown time into minutes and seconds.
`default_nettype none

module cdts_time_split (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire cdts_pkg::t_beat i_beat,
    cdts_out_if.source          o_out
);

    localparam int P1_W = cdts_pkg::MS_W + cdts_pkg::R1000_W;
    localparam int P2_W = cdts_pkg::SEC_W + cdts_pkg::R60_W;

    logic                       r_v1, r_v2, r_v3;
    cdts_pkg::t_beat            r_b1, r_b2, r_b3;
    logic [P1_W-1:0]            r_p1;
    logic [P2_W-1:0]            r_p2;
    logic [cdts_pkg::SEC_W-1:0] r_ts2;
    logic [cdts_pkg::MIN_W-1:0] r_min3;
    logic [cdts_pkg::SS_W-1:0]  r_sec3;

    logic                       load1, load2, load3;
    logic [cdts_pkg::SEC_W-1:0] total_sec;
    logic [cdts_pkg::MIN_W-1:0] minutes;
    logic [cdts_pkg::SEC_W-1:0] min_x60;
    logic [cdts_pkg::SEC_W-1:0] sec_rem;

    assign load3   = !r_v3 || o_out.ready;
    assign load2   = !r_v2 || load3;
    assign load1   = !r_v1 || load2;
    assign o_ready = load1;

    assign total_sec = r_p1[cdts_pkg::SHIFT_1000 +: cdts_pkg::SEC_W];
    assign minutes   = r_p2[cdts_pkg::SHIFT_60 +: cdts_pkg::MIN_W];
    assign min_x60   = cdts_pkg::SEC_W'(minutes) * cdts_pkg::SEC_W'(60);
    assign sec_rem   = r_ts2 - min_x60;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) r_v1 <= i_valid;
            if (load2) r_v2 <= r_v1;
            if (load3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_b1 <= i_beat;
            r_p1 <= P1_W'(i_beat.shown_ms) * P1_W'(cdts_pkg::RECIP_1000);
        end
        if (load2) begin
            r_b2  <= r_b1;
            r_ts2 <= total_sec;
            r_p2  <= P2_W'(total_sec) * P2_W'(cdts_pkg::RECIP_60);
        end
        if (load3) begin
            r_b3   <= r_b2;
            r_min3 <= minutes;
            r_sec3 <= sec_rem[cdts_pkg::SS_W-1:0];
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.run_state      = r_b3.run_state;
    assign o_out.shown_ms       = r_b3.shown_ms;
    assign o_out.shown_minutes  = r_min3;
    assign o_out.shown_seconds  = r_sec3;
    assign o_out.finished_pulse = r_b3.finished_pulse;
    assign o_out.state_changed  = r_b3.state_changed;

endmodule

`default_nettype wire

@@ rtl/core/countdown_timer_stopwatch_core.sv @@
// Top level of the countdown timer / stopwatch core.
//
// Usage:
//   i_in carries one beat per tick (TICK_MS milliseconds) or command: start,
//   pause, reset, add time, set duration. o_out returns one beat per input
//   beat: run state, shown time in ms, whole minutes, seconds in the minute,
//   the finished pulse and the state change flag.
//   i_cfg_we / i_cfg_wdata write the mode (0 timer, 1 stopwatch) while idle;
//   follow a mode change with a reset command.
//   Pipeline: an accepted input beat passes through the state update register,
//   two reciprocal product registers and the output register before its result
//   is valid. Throughput: one beat per cycle while o_out.ready is high; the state
//   update loop closes through a single register.
//   Reset: run state idle, all counts zero, mode timer, pipeline empty.
//   Stall: when o_out.ready is low the pipeline holds; i_in.ready stays high
//   until all four stages are full.
`default_nettype none

module countdown_timer_stopwatch_core #(
    parameter int TICK_MS     = 100,
    parameter int MAX_SECONDS = 86399
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    cdts_in_if.sink   i_in,
    cdts_out_if.source o_out
);

    localparam int MS_W = cdts_pkg::MS_W;
    localparam logic [MS_W-1:0]           MAX_MS  = MS_W'(MAX_SECONDS * 1000);
    localparam logic [MS_W-1:0]           TICK    = MS_W'(TICK_MS);
    localparam logic [cdts_pkg::SEC_W-1:0] MAX_SEC = cdts_pkg::SEC_W'(MAX_SECONDS);

    function automatic logic [MS_W-1:0] sat_add(input logic [MS_W-1:0] a,
                                                input logic [MS_W-1:0] b);
        logic [MS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, MAX_MS}) ? MAX_MS : s[MS_W-1:0];
    endfunction

    logic              r_mode;
    cdts_pkg::t_phase  r_phase;
    logic [MS_W-1:0]   r_dur, r_rem, r_ela;
    logic              r_v0;
    cdts_pkg::t_beat   r_beat;

    cdts_pkg::t_phase  n_phase;
    logic [MS_W-1:0]   n_dur, n_rem, n_ela;
    cdts_pkg::t_beat   n_beat;

    logic                       accept;
    logic                       split_ready;
    logic                       pulse;
    logic                       forced;
    logic [cdts_pkg::SEC_W-1:0] secs;
    logic [MS_W-1:0]            amt_ms;

    assign i_in.ready = !r_v0 || split_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_phase = r_phase;
        n_dur   = r_dur;
        n_rem   = r_rem;
        n_ela   = r_ela;
        pulse   = 1'b0;
        forced  = 1'b0;
        secs    = (i_in.amount_seconds > MAX_SEC) ? MAX_SEC : i_in.amount_seconds;
        amt_ms  = MS_W'(secs) * MS_W'(1000);
        case (cdts_pkg::t_op'(i_in.operation))
            cdts_pkg::OP_TICK: begin
                if (r_phase == cdts_pkg::PH_RUNNING) begin
                    if (!r_mode) begin
                        if (r_rem <= TICK) begin
                            n_rem   = '0;
                            n_phase = cdts_pkg::PH_FINISHED;
                            pulse   = 1'b1;
                        end else begin
                            n_rem = r_rem - TICK;
                        end
                    end else begin
                        n_ela = sat_add(r_ela, TICK);
                    end
                end
            end
            cdts_pkg::OP_START: begin
                if (r_phase == cdts_pkg::PH_FINISHED) begin
                    n_ela  = '0;
                    n_rem  = r_dur;
                    forced = 1'b1;
                end
                n_phase = cdts_pkg::PH_RUNNING;
            end
            cdts_pkg::OP_PAUSE: begin
                if (r_phase == cdts_pkg::PH_RUNNING) n_phase = cdts_pkg::PH_PAUSED;
            end
            cdts_pkg::OP_RESET: begin
                n_phase = cdts_pkg::PH_IDLE;
                n_ela   = '0;
                n_rem   = r_dur;
            end
            cdts_pkg::OP_ADD_TIME: begin
                if (!r_mode) begin
                    n_rem = sat_add(r_rem, amt_ms);
                    n_dur = sat_add(r_dur, amt_ms);
                    if (r_phase == cdts_pkg::PH_FINISHED) n_phase = cdts_pkg::PH_RUNNING;
                end
            end
            cdts_pkg::OP_SET_DURATION: begin
                n_dur = amt_ms;
                if (r_phase == cdts_pkg::PH_IDLE) n_rem = amt_ms;
            end
            default: ;
        endcase
        n_beat.run_state      = n_phase;
        n_beat.shown_ms       = r_mode ? n_ela : n_rem;
        n_beat.finished_pulse = pulse;
        n_beat.state_changed  = forced || (n_phase != r_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= cdts_pkg::PH_IDLE;
            r_dur   <= '0;
            r_rem   <= '0;
            r_ela   <= '0;
            r_v0    <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            if (accept) begin
                r_phase <= n_phase;
                r_dur   <= n_dur;
                r_rem   <= n_rem;
                r_ela   <= n_ela;
                r_v0    <= 1'b1;
            end else if (split_ready) begin
                r_v0 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_beat <= n_beat;
    end

    cdts_time_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_ready (split_ready),
        .i_beat  (r_beat),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
